>>> src/periodic_task_dispatcher_assert.svh
// Assertion macros for the periodic task dispatcher.
`ifndef PERIODIC_TASK_DISPATCHER_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PTD_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptd: same-cycle check failed");
// Next-cycle implication.
`define PTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptd: next-cycle check failed");
`else
`define PTD_ASSERT_HOLDS(label, clk, rst, ante, cons)
`define PTD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> src/ptd_pkg.sv
// Shared types, constants and slot update function of the periodic task dispatcher.
package ptd_pkg;

   localparam int TASK_SLOTS = 8;
   localparam int TICK_WIDTH = 16;
   localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

   // Operation codes
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_CREATE  = 3'd1;
   localparam logic [2:0] OP_DELETE  = 3'd2;
   localparam logic [2:0] OP_RESUME  = 3'd3;
   localparam logic [2:0] OP_SUSPEND = 3'd4;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_USED  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_RANGE = 2'd3;

   // Requested state codes at create
   localparam logic [1:0] INIT_READY     = 2'd0;
   localparam logic [1:0] INIT_SUSPENDED = 2'd2;

   typedef enum logic [1:0] {
      RS_READY     = 2'd0,
      RS_BLOCKED   = 2'd1,
      RS_SUSPENDED = 2'd2
   } run_state_type;

   typedef struct packed {
      logic                  used;
      run_state_type         run_state;
      logic [TICK_WIDTH-1:0] period;
      logic [TICK_WIDTH-1:0] countdown;
   } slot_type;

   typedef struct packed {
      slot_type slot;
      logic     dispatch;
   } eval_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  task_slot;
      logic [15:0] period_ticks;
      logic [15:0] first_delay;
      logic [1:0]  initial_state;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic       dispatch_valid;
      logic [5:0] dispatched_slot;
      logic       last;
   } rsp_payload_type;

   // One tick's worth of update for a single slot.
   function automatic eval_type slot_eval(input slot_type cur);
      eval_type      res;
      run_state_type st;
      res          = '0;
      res.slot     = cur;
      res.dispatch = 1'b0;
      st           = cur.run_state;
      if (cur.used && (cur.run_state != RS_SUSPENDED)) begin
         if (cur.countdown == '0) begin
            st = RS_READY;
         end
         if (st == RS_READY) begin
            res.slot.countdown = cur.period - TICK_WIDTH'(1);
            res.slot.run_state = RS_BLOCKED;
            res.dispatch       = 1'b1;
         end else begin
            res.slot.countdown = cur.countdown - TICK_WIDTH'(1);
            res.slot.run_state = st;
         end
      end
      return res;
   endfunction

endpackage

>>> src/ptd_req_if.sv
// Request channel of the periodic task dispatcher.
interface ptd_req_if;
   import ptd_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> src/ptd_rsp_if.sv
// Response channel of the periodic task dispatcher.
interface ptd_rsp_if;
   import ptd_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> src/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher: slot ring, sequencer and response register.
`include "periodic_task_dispatcher_assert.svh"

// Periodic task dispatcher. Holds TASK_SLOTS task slots in a ring of cells; slot
// index is priority, lowest first. Create, delete, resume and suspend each give a
// single transfer carrying the status. A tick rotates the ring once through the
// head cell, one slot per cycle while no earlier dispatch is held up by the
// response side. From its transfer to the next request a tick goes through the
// accepting idle state, the walk of every slot and the closing flush state, plus
// any stalls of the response side. It gives one transfer per dispatched slot in
// slot order, the final one flagged with last, or a single transfer with
// dispatch_valid low when nothing was due. One item is in flight at a time; a
// request is taken only when the output register is empty or its result leaves
// in that same cycle. No clearing pass after reset: used marks and states reset
// at once.
module periodic_task_dispatcher (
   input logic      clock,
   input logic      reset,
   ptd_req_if.sink  req_bus,
   ptd_rsp_if.source rsp_bus
);
   import ptd_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FLUSH
   } fsm_type;

   localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(TASK_SLOTS - 1);

   // Sequencer registers
   fsm_type         state_ff, state_in;
   logic [SLOT_W-1:0] step_ff, step_in;
   logic            pend_valid_ff, pend_valid_in;
   logic [5:0]      pend_slot_ff, pend_slot_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // Ring
   slot_type        cell_q [TASK_SLOTS];
   slot_type        wr_data;
   logic            wr_apply;
   logic            shift_en;
   eval_type        head_eval;

   // Request decode
   req_payload_type   req;
   logic              accept;
   logic              in_range;
   logic [SLOT_W-1:0] sel_idx;
   slot_type          sel;
   logic [1:0]        op_status;
   logic [TICK_WIDTH-1:0] period_cut;
   run_state_type     init_state;

   // Output side
   logic            out_free;
   logic            push;
   rsp_payload_type push_data;

   assign req      = req_bus.payload;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) && out_free;
   assign accept   = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

   // Head cell always holds the slot being walked.
   assign head_eval = slot_eval(cell_q[0]);

   genvar gi;
   generate
      for (gi = 0; gi < TASK_SLOTS; gi++) begin : g_cell
         slot_type next_data;
         logic     wr_en;
         if (gi == TASK_SLOTS - 1) begin : g_wrap
            assign next_data = head_eval.slot;   // updated head re-enters at the tail
         end else begin : g_pass
            assign next_data = cell_q[gi+1];
         end
         assign wr_en = wr_apply && (sel_idx == SLOT_W'(gi));
         ptd_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (shift_en),
            .shift_data (next_data),
            .write_en   (wr_en),
            .write_data (wr_data),
            .slot_q     (cell_q[gi])
         );
      end
   endgenerate

   // Register operations: status and the slot image to write back
   assign in_range   = req.task_slot < 8'(TASK_SLOTS);
   assign sel_idx    = req.task_slot[SLOT_W-1:0];
   assign sel        = cell_q[sel_idx];
   assign period_cut = (TICK_WIDTH'(req.period_ticks) == '0) ? TICK_WIDTH'(1)
                                                             : TICK_WIDTH'(req.period_ticks);

   always_comb begin
      priority if (req.initial_state == INIT_READY) begin
         init_state = RS_READY;
      end else if (req.initial_state == INIT_SUSPENDED) begin
         init_state = RS_SUSPENDED;
      end else begin
         init_state = RS_BLOCKED;   // blocked, and the unused fourth code
      end
   end

   always_comb begin
      logic do_write;
      do_write  = 1'b0;
      wr_data   = sel;
      op_status = STATUS_OK;
      unique case (req.operation)
         OP_CREATE: begin
            if (sel.used) begin
               op_status = STATUS_USED;
            end else begin
               do_write  = 1'b1;
               wr_data   = '{used: 1'b1, run_state: init_state, period: period_cut,
                             countdown: TICK_WIDTH'(req.first_delay)};
            end
         end
         OP_DELETE, OP_RESUME, OP_SUSPEND: begin
            if (!sel.used) begin
               op_status = STATUS_EMPTY;
            end else begin
               do_write = 1'b1;
               unique case (req.operation)
                  OP_DELETE:  wr_data.used      = 1'b0;
                  OP_RESUME:  wr_data.run_state = RS_BLOCKED;
                  default:    wr_data.run_state = RS_SUSPENDED;
               endcase
            end
         end
         default: begin
            // tick, or an unknown code that is simply acknowledged
         end
      endcase
      if (!in_range && (req.operation == OP_CREATE || req.operation == OP_DELETE ||
                        req.operation == OP_RESUME || req.operation == OP_SUSPEND)) begin
         op_status = STATUS_RANGE;
         do_write  = 1'b0;
      end
      wr_apply = accept && do_write;
   end

   // Sequencer. A dispatch is held back until the next dispatch or the flush state so the final one can carry last.
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      shift_en      = 1'b0;
      push          = 1'b0;
      push_data     = '{status: STATUS_OK, dispatch_valid: 1'b0,
                        dispatched_slot: 6'd0, last: 1'b1};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req.operation == OP_TICK) begin
                  state_in      = S_WALK;
                  step_in       = '0;
                  pend_valid_in = 1'b0;
               end else begin
                  push             = 1'b1;
                  push_data.status = op_status;
               end
            end
         end
         S_WALK: begin
            // Stall only when an earlier dispatch has to leave and cannot.
            if (!(head_eval.dispatch && pend_valid_ff) || out_free) begin
               shift_en = 1'b1;
               if (head_eval.dispatch) begin
                  if (pend_valid_ff) begin
                     push      = 1'b1;
                     push_data = '{status: STATUS_OK, dispatch_valid: 1'b1,
                                   dispatched_slot: pend_slot_ff, last: 1'b0};
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = 6'(step_ff);
               end
               if (step_ff == LAST_STEP) begin
                  state_in = S_FLUSH;
               end else begin
                  step_in = SLOT_W'(step_ff + 1'b1);
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               push = 1'b1;
               if (pend_valid_ff) begin
                  push_data = '{status: STATUS_OK, dispatch_valid: 1'b1,
                                dispatched_slot: pend_slot_ff, last: 1'b1};
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Output register: a new result replaces one that is leaving this cycle.
      if (push) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = push_data;
      end else begin
         rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
         rsp_payload_in = rsp_payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         pend_valid_ff  <= pend_valid_in;
         pend_slot_ff   <= pend_slot_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // A taken tick starts the walk.
   `PTD_ASSERT_NEXT(a_tick_starts_walk, clock, reset, accept && req.operation == OP_TICK, state_ff == S_WALK)
   // Dispatches pushed mid-walk are never the final transfer.
   `PTD_ASSERT_HOLDS(a_walk_push_not_last, clock, reset, state_ff == S_WALK && push, push_data.dispatch_valid && !push_data.last)
   // The walk only closes after the last slot went through the head.
   `PTD_ASSERT_HOLDS(a_flush_after_full_walk, clock, reset, state_ff == S_FLUSH, step_ff == LAST_STEP)

endmodule

>>> src/ptd_cell.sv
// One task slot cell of the dispatcher ring.
module ptd_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  ptd_pkg::slot_type shift_data,
   input  logic             write_en,
   input  ptd_pkg::slot_type write_data,
   output ptd_pkg::slot_type slot_q
);
   import ptd_pkg::*;

   logic                  used_ff;
   run_state_type         state_ff;
   logic [TICK_WIDTH-1:0] period_ff;
   logic [TICK_WIDTH-1:0] count_ff;
   slot_type              slot_in;

   // Direct write wins; the ring only moves during a tick.
   always_comb begin
      priority if (write_en) begin
         slot_in = write_data;
      end else if (shift_en) begin
         slot_in = shift_data;
      end else begin
         slot_in = slot_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         state_ff <= RS_READY;
      end else begin
         used_ff  <= slot_in.used;
         state_ff <= slot_in.run_state;
      end
   end

   always_ff @(posedge clock) begin
      period_ff <= slot_in.period;
      count_ff  <= slot_in.countdown;
   end

   assign slot_q = '{used: used_ff, run_state: state_ff,
                     period: period_ff, countdown: count_ff};

endmodule

>>> tb/ptd_dispatch_checker.sv
// Checker for the periodic task dispatcher: slot table prediction and response comparison.
`timescale 1ns / 1ps

module ptd_dispatch_checker (
   input  logic clock,
   input  logic reset,
   ptd_req_if   req_mon,
   ptd_rsp_if   rsp_mon,
   output int   fault_count,
   output int   owed_count
);
   import ptd_pkg::*;

   // Own copy of the slot table
   bit                    slot_live   [TASK_SLOTS];
   run_state_type         slot_mode   [TASK_SLOTS];
   logic [TICK_WIDTH-1:0] slot_period [TASK_SLOTS];
   logic [TICK_WIDTH-1:0] slot_count  [TASK_SLOTS];

   rsp_payload_type due_q[$];
   int              faults = 0;

   // Walks the table for a tick, or applies a slot operation, and queues what should come back.
   function automatic void predict_outcome(input req_payload_type item);
      rsp_payload_type       held;
      rsp_payload_type       note;
      logic [TICK_WIDTH-1:0] per;
      bit                    have;
      int                    s;
      held      = '0;
      note      = '0;
      note.last = 1'b1;
      have      = 1'b0;
      per       = item.period_ticks[TICK_WIDTH-1:0];
      s         = int'(item.task_slot);
      case (item.operation)
         OP_TICK: begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
               if (slot_live[i] && slot_mode[i] != RS_SUSPENDED) begin
                  if (slot_count[i] == '0) begin
                     slot_mode[i] = RS_READY;
                  end
                  if (slot_mode[i] == RS_READY) begin
                     slot_count[i] = slot_period[i] - 1'b1;
                     slot_mode[i]  = RS_BLOCKED;
                     if (have) begin
                        due_q.push_back(held);
                     end
                     held                 = '0;
                     held.status          = STATUS_OK;
                     held.dispatch_valid  = 1'b1;
                     held.dispatched_slot = 6'(i);
                     have                 = 1'b1;
                  end else begin
                     slot_count[i] = slot_count[i] - 1'b1;
                  end
               end
            end
            if (have) begin
               held.last = 1'b1;
               due_q.push_back(held);
            end else begin
               due_q.push_back(note);
            end
         end
         OP_CREATE, OP_DELETE, OP_RESUME, OP_SUSPEND: begin
            if (item.task_slot >= TASK_SLOTS) begin
               note.status = STATUS_RANGE;
            end else if (item.operation == OP_CREATE) begin
               if (slot_live[s]) begin
                  note.status = STATUS_USED;
               end else begin
                  if (per == '0) begin
                     per = TICK_WIDTH'(1);
                  end
                  case (item.initial_state)
                     INIT_READY:     slot_mode[s] = RS_READY;
                     INIT_SUSPENDED: slot_mode[s] = RS_SUSPENDED;
                     default:        slot_mode[s] = RS_BLOCKED;
                  endcase
                  slot_period[s] = per;
                  slot_count[s]  = item.first_delay[TICK_WIDTH-1:0];
                  slot_live[s]   = 1'b1;
               end
            end else if (!slot_live[s]) begin
               note.status = STATUS_EMPTY;
            end else if (item.operation == OP_DELETE) begin
               slot_live[s] = 1'b0;
            end else if (item.operation == OP_RESUME) begin
               slot_mode[s] = RS_BLOCKED;
            end else begin
               slot_mode[s] = RS_SUSPENDED;
            end
            due_q.push_back(note);
         end
         default: begin
            // spare codes are ignored but still answered
            due_q.push_back(note);
         end
      endcase
   endfunction

   function automatic void check_field(input string label, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
         faults++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_mode[i] = RS_READY;
         end
         due_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predict_outcome(req_mon.payload);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (due_q.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, got %p", $time, got);
               faults++;
            end else begin
               want = due_q.pop_front();
               check_field("status", 8'(want.status), 8'(got.status));
               check_field("dispatch_valid", 8'(want.dispatch_valid), 8'(got.dispatch_valid));
               check_field("dispatched_slot", 8'(want.dispatched_slot),
                           8'(got.dispatched_slot));
               check_field("last", 8'(want.last), 8'(got.last));
            end
         end
      end
      fault_count <= faults;
      owed_count  <= due_q.size();
   end

endmodule

>>> tb/testbench.sv
// Top of the periodic task dispatcher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import ptd_pkg::*;

   // Spare operation codes and the undefined initial state, which the block must tolerate
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   localparam logic [1:0] INIT_SPARE     = 2'd3;
   localparam int         ITEMS_PER_PHASE = 131;
   localparam int         TAIL_CYCLES     = 40;

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct = 17;
   int   rsp_idle_pct  = 72;
   int   fault_count;
   int   owed_count;

   ptd_req_if req_chan ();
   ptd_rsp_if rsp_chan ();

   always #5 clock = ~clock;

   periodic_task_dispatcher u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_chan),
      .rsp_bus (rsp_chan)
   );

   ptd_dispatch_checker u_dispatch_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .fault_count (fault_count),
      .owed_count  (owed_count)
   );

   // Receiver back-pressure: ready drops at random per the current idle percentage.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic req_payload_type make_item(input logic [2:0] op, input logic [7:0] slot,
                                                 input logic [15:0] per,
                                                 input logic [15:0] dly,
                                                 input logic [1:0] init);
      req_payload_type item;
      item.operation     = op;
      item.task_slot     = slot;
      item.period_ticks  = per;
      item.first_delay   = dly;
      item.initial_state = init;
      return item;
   endfunction

   // Mostly well-formed traffic on in-range slots with short periods so that ticks
   // dispatch often; a tail of out-of-range slots, huge timings, spare codes and noise.
   function automatic req_payload_type random_item();
      req_payload_type item;
      int              pick;
      pick = $urandom_range(99);
      item.task_slot = ($urandom_range(9) == 0) ? 8'($urandom_range(255, TASK_SLOTS))
                                                : 8'($urandom_range(TASK_SLOTS - 1));
      item.period_ticks  = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                    : 16'($urandom_range(5));
      item.first_delay   = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                    : 16'($urandom_range(6));
      item.initial_state = 2'($urandom_range(3));
      if (pick < 45) begin
         item.operation = OP_TICK;
      end else if (pick < 63) begin
         item.operation = OP_CREATE;
      end else if (pick < 72) begin
         item.operation = OP_DELETE;
      end else if (pick < 81) begin
         item.operation = OP_RESUME;
      end else if (pick < 90) begin
         item.operation = OP_SUSPEND;
      end else if (pick < 94) begin
         item.operation = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      end else begin
         // pure noise in every field
         item.operation    = 3'($urandom_range(7));
         item.task_slot    = 8'($urandom_range(255));
         item.period_ticks = 16'($urandom_range(65535));
         item.first_delay  = 16'($urandom_range(65535));
      end
      return item;
   endfunction

   // One request transfer: random idle cycles first, then hold valid until ready is seen.
   // Valid is left high on return so back-to-back transfers need no extra assignment.
   task automatic send(input req_payload_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty tick, status codes, field extremes and the odd cases
      send(make_item(OP_TICK, 8'd0, 16'd0, 16'd0, INIT_READY));
      send(make_item(OP_CREATE, 8'd0, 16'd1, 16'd0, INIT_READY));
      send(make_item(OP_CREATE, 8'd0, 16'd3, 16'd2, RS_BLOCKED));            // slot taken
      send(make_item(OP_CREATE, 8'(TASK_SLOTS), 16'd1, 16'd0, INIT_READY));  // just past table
      send(make_item(OP_CREATE, 8'd255, 16'hFFFF, 16'hFFFF, INIT_SPARE));
      send(make_item(OP_CREATE, 8'(TASK_SLOTS - 1), 16'd0, 16'd0, INIT_SPARE)); // zero period
      send(make_item(OP_CREATE, 8'd3, 16'hFFFF, 16'hFFFF, INIT_SUSPENDED));
      send(make_item(OP_CREATE, 8'd5, 16'd2, 16'd1, RS_BLOCKED));
      send(make_item(OP_TICK, 8'd0, 16'd0, 16'd0, INIT_READY));
      send(make_item(OP_TICK, 8'd0, 16'd0, 16'd0, INIT_READY));
      send(make_item(OP_SUSPEND, 8'd0, 16'd0, 16'd0, INIT_READY));
      send(make_item(OP_TICK, 8'd0, 16'd0, 16'd0, INIT_READY));
      send(make_item(OP_RESUME, 8'd0, 16'd0, 16'd0, INIT_READY));
      send(make_item(OP_RESUME, 8'd3, 16'd0, 16'd0, INIT_READY));           // suspended to blocked
      send(make_item(OP_DELETE, 8'd6, 16'd0, 16'd0, INIT_READY));           // empty slot
      send(make_item(OP_RESUME, 8'd6, 16'd0, 16'd0, INIT_READY));
      send(make_item(OP_SUSPEND, 8'd6, 16'd0, 16'd0, INIT_READY));
      send(make_item(OP_DELETE, 8'd3, 16'd0, 16'd0, INIT_READY));
      send(make_item(OP_DELETE, 8'd200, 16'd0, 16'd0, INIT_READY));         // out of range
      send(make_item(OP_SPARE_FIRST, 8'd1, 16'd1, 16'd1, INIT_READY));
      send(make_item(OP_SPARE_LAST, 8'd2, 16'd2, 16'd2, INIT_READY));
      for (int i = 1; i < TASK_SLOTS - 1; i++) begin
         if (i != 5) begin
            send(make_item(OP_CREATE, 8'(i), 16'd1, 16'd0, INIT_READY));
         end
      end
      send(make_item(OP_TICK, 8'd0, 16'd0, 16'd0, INIT_READY));             // full table

      // Random part in three idling phases: sender light / receiver heavy, the reverse,
      // then full throughput on both sides.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 17;
               rsp_idle_pct  = 72;
            end
            1: begin
               send_idle_pct = 72;
               rsp_idle_pct  = 17;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         repeat (ITEMS_PER_PHASE) send(random_item());
      end
      req_chan.valid <= 1'b0;

      // Drain: wait for every predicted transfer, then give the block time to show strays.
      @(posedge clock);
      while (owed_count != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fault_count == 0 && owed_count == 0) begin
         $display("[periodic_task_dispatcher] OK");
      end else begin
         $display("[periodic_task_dispatcher] ERROR");
      end
      $finish;
   end

   // Watchdog: ends a hung run with an error.
   initial begin
      #5_000_000;
      $display("[periodic_task_dispatcher] ERROR");
      $finish;
   end

endmodule
